/* sv/hafr_pkg.sv */
package hafr_pkg;

  localparam logic [7:0]  FlagByte = 8'h7E;
  localparam logic [7:0]  EscByte  = 8'h7D;
  localparam logic [7:0]  EscMask  = 8'h20;
  localparam logic [15:0] FcsPoly  = 16'h8408;
  localparam logic [15:0] FcsInit  = 16'hFFFF;

  // Longest expansion of one request: flag, two-byte escape of the payload,
  // two two-byte escapes of the FCS, closing flag.
  localparam int unsigned MaxOut  = 8;
  localparam int unsigned OutIdxW = $clog2(MaxOut);
  localparam int unsigned OutCntW = $clog2(MaxOut + 1);

  // One expanded request, handed from the encoder to the emitter.
  typedef struct packed {
    logic [MaxOut-1:0][7:0] bytes;
    logic [OutIdxW-1:0]     last_idx;
    logic                   fend;
  } hafr_item_t;

  function automatic logic needs_esc(input logic [7:0] b);
    needs_esc = (b == FlagByte) || (b == EscByte);
  endfunction

  // FCS-16, reflected, one byte.
  function automatic logic [15:0] fcs_step(input logic [15:0] fcs, input logic [7:0] b);
    logic [15:0] r;
    r = fcs ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ FcsPoly) : (r >> 1);
    end
    fcs_step = r;
  endfunction

endpackage

/* sv/hafr_encode.sv */
module hafr_encode
  import hafr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       item_valid_o,
  input  logic       item_take_i,
  output hafr_item_t item_o
);

  logic        s1_valid_q, s1_valid_d;
  logic [7:0]  byte_q;
  logic        last_q;
  logic [15:0] fcs_q, fcs_d;
  logic        in_frame_q, in_frame_d;
  logic        in_acc;
  logic        take;
  logic [15:0] fcs_new;
  logic [15:0] fcs_res;
  logic [2:0][7:0] piece;
  logic [OutCntW-1:0] pos;
  hafr_item_t  item;

  assign in_acc       = in_valid_i && in_ready_o;
  assign take         = s1_valid_q && item_take_i;
  assign in_ready_o   = !s1_valid_q || item_take_i;
  assign item_valid_o = s1_valid_q;
  assign item_o       = item;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (take) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
  end

  // Expand the held request into its line bytes.
  always_comb begin
    fcs_new  = fcs_step(fcs_q, byte_q);
    fcs_res  = ~fcs_new;
    piece[0] = byte_q;
    piece[1] = fcs_res[7:0];
    piece[2] = fcs_res[15:8];
    item     = '0;
    pos      = '0;
    if (!in_frame_q) begin
      item.bytes[pos[OutIdxW-1:0]] = FlagByte;
      pos = pos + 1'b1;
    end
    for (int k = 0; k < 3; k++) begin
      if (k == 0 || last_q) begin
        if (needs_esc(piece[k])) begin
          item.bytes[pos[OutIdxW-1:0]] = EscByte;
          pos = pos + 1'b1;
          item.bytes[pos[OutIdxW-1:0]] = piece[k] ^ EscMask;
        end else begin
          item.bytes[pos[OutIdxW-1:0]] = piece[k];
        end
        pos = pos + 1'b1;
      end
    end
    if (last_q) begin
      item.bytes[pos[OutIdxW-1:0]] = FlagByte;
      item.fend = 1'b1;
      pos = pos + 1'b1;
    end
    item.last_idx = OutIdxW'(pos - 1'b1);
  end

  always_comb begin
    fcs_d      = fcs_q;
    in_frame_d = in_frame_q;
    if (take) begin
      fcs_d      = last_q ? FcsInit : fcs_new;
      in_frame_d = !last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcs_q      <= FcsInit;
      in_frame_q <= 1'b0;
    end else begin
      fcs_q      <= fcs_d;
      in_frame_q <= in_frame_d;
    end
  end

  a_close_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && last_q) |=> (!in_frame_q && fcs_q == FcsInit))
    else $error("frame close did not restore FCS and frame state");

  a_open_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !in_frame_q) |-> (item.bytes[0] == FlagByte))
    else $error("new frame missing opening flag");

  a_mid_no_fend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !last_q) |=> in_frame_q)
    else $error("frame closed on a non-final byte");

endmodule

/* sv/hafr_emit.sv */
module hafr_emit
  import hafr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       item_valid_i,
  output logic       item_take_o,
  input  hafr_item_t item_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       frame_end_o
);

  hafr_item_t          buf_q;
  logic                buf_valid_q, buf_valid_d;
  logic [OutIdxW-1:0]  idx_q, idx_d;
  logic                at_last;
  logic                out_acc;
  logic                can_load;
  logic                load;

  assign at_last     = (idx_q == buf_q.last_idx);
  assign out_acc     = buf_valid_q && out_ready_i;
  assign can_load    = !buf_valid_q || (out_ready_i && at_last);
  assign load        = can_load && item_valid_i;
  assign item_take_o = can_load;

  assign out_valid_o = buf_valid_q;
  assign out_byte_o  = buf_q.bytes[idx_q];
  assign run_last_o  = at_last;
  assign frame_end_o = at_last && buf_q.fend;

  always_comb begin
    buf_valid_d = buf_valid_q;
    idx_d       = idx_q;
    if (load) begin
      buf_valid_d = 1'b1;
      idx_d       = '0;
    end else if (out_acc) begin
      if (at_last) begin
        buf_valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      buf_valid_q <= buf_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      buf_q <= item_i;
    end
  end

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_valid_q |-> (idx_q <= buf_q.last_idx))
    else $error("emit index past end of request");

  a_fend_is_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (buf_valid_q && frame_end_o) |-> (out_byte_o == FlagByte))
    else $error("frame end on a non-flag byte");

endmodule

/* sv/hdlc_async_framer.sv */
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i/in_ready_o   | data_byte_i, last_byte_i
// out     | output    | out_valid_o/out_ready_i | out_byte_o, run_last_o, frame_end_o
//
// Each request yields 1 to 8 line bytes, one per cycle on the out channel while
// out_ready_i is high, limited by the emitter's byte register (1 to 2 line bytes
// per mid-frame request, up to 8 for one that opens and closes a frame). An
// accepted request passes through the encoder's input register and the emitter's
// byte register before its first line byte goes out. Reset clears all control state,
// the FCS to 0xFFFF and the frame-open flag; no clearing pass is needed. A stall
// on out holds the current byte; the input register still takes one more request.
module hdlc_async_framer
  import hafr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       frame_end_o
);

  // Encoder: input register, FCS and frame state, expansion of one request
  // into its flag, escaped bytes, FCS bytes and closing flag.
  hafr_item_t item;
  logic       item_valid;
  logic       item_take;

  hafr_encode u_encode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .item_valid_o(item_valid),
    .item_take_i (item_take),
    .item_o      (item)
  );

  // Emitter: hold the expanded request and advance one byte per accepted
  // output; reload in the same cycle the final byte goes out.
  hafr_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(item_valid),
    .item_take_o (item_take),
    .item_i      (item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o),
    .frame_end_o (frame_end_o)
  );

endmodule
